@@ rtl/wspd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wspd_pkg;

  localparam int CAPTURE_BITS_DEF   = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int SCALE_W = 24;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 12;
  localparam int SPEED_W = 25;
  localparam int TARGET_W = 24;
  localparam int ERR_W   = 26;
  localparam int INTEG_W = 32;
  localparam int DRIVE_W = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd644429;
  localparam logic [GAIN_W-1:0]  GAIN_P_RST = 16'd2688;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST = 16'd256;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST = 16'd3;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 12'd1000;
  localparam logic [LIMIT_W-1:0] PWM_RST   = 12'd1000;
  localparam logic               SIDE_RST  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_SCALE = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_I      = 3'd2,
    REG_GAIN_D      = 3'd3,
    REG_OUT_LIMIT   = 3'd4,
    REG_PWM_PERIOD  = 3'd5,
    REG_WHEEL_SIDE  = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAP,
    S_DIV,
    S_SIGN,
    S_ERR,
    S_MP,
    S_MI,
    S_MD,
    S_SUM,
    S_CLAMP,
    S_MAP
  } state_e;

endpackage

`default_nettype wire

@@ rtl/wheel_speed_pid_drive_core.sv @@
// Capture request: 24 divider steps of one restoring subtractor that is reused
// for every step, then sign and map; the divider is skipped when the period is zero.
// Tick request: error, three passes through one multiplier, sum, clamp, map.
// One request at a time; the input stalls until the result is loaded into the
// output register. Reset loads register defaults and clears all loop state.
`timescale 1ns / 1ps
`default_nettype none

module wheel_speed_pid_drive_core #(
  parameter int CAPTURE_BITS   = wspd_pkg::CAPTURE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = wspd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [wspd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [wspd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire                                  command_i,
  input  wire  [CAPTURE_BITS-1:0]              capture_value_i,
  input  wire                                  direction_level_i,
  input  wire  signed [wspd_pkg::TARGET_W-1:0] target_speed_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic signed [wspd_pkg::SPEED_W-1:0]  measured_speed_o,
  output logic signed [wspd_pkg::DRIVE_W-1:0]  drive_value_o,
  output logic [wspd_pkg::LIMIT_W-1:0]         compare_value_o,
  output logic                                 direction_pin_o
);
  import wspd_pkg::*;

  localparam int CB     = CAPTURE_BITS;
  localparam int CNT_W  = $clog2(SCALE_W + 1);
  localparam int MA_W   = GAIN_W + 1;
  localparam int MB_W   = INTEG_W + 2;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = PROD_W + 2;

  state_e state_q, state_d;

  logic [SCALE_W-1:0] scale_q;
  logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [LIMIT_W-1:0] limit_q, pwm_q;
  logic               side_q;

  logic                     cmd_q;
  logic [CB-1:0]            cap_q;
  logic                     level_q;
  logic signed [TARGET_W-1:0] target_q;

  logic [CB-1:0]             last_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [ERR_W-1:0]   prev_q;
  logic signed [DRIVE_W-1:0] drive_q;

  logic [CB-1:0]       period_q;
  logic [CB-1:0]       rem_q;
  logic [SCALE_W-1:0]  quo_q;
  logic [CNT_W-1:0]    cnt_q;

  logic signed [ERR_W-1:0]  err_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic                      out_valid_q;
  logic signed [SPEED_W-1:0] out_speed_q;
  logic signed [DRIVE_W-1:0] out_drive_q;
  logic [LIMIT_W-1:0]        out_cmp_q;
  logic                      out_pin_q;

  logic                in_take, out_free;
  logic [CB:0]         cap_diff;
  logic [CB-1:0]       period_c;
  logic [CB:0]         rem_sh;
  logic [CB+1:0]       div_sub;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_sh;
  logic [PROD_W-INTEG_W:0]  prod_hi;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [ERR_W:0]     err_delta;
  logic signed [ACC_W-1:0]   lim_pos;
  logic signed [DRIVE_W:0]   per_s, drv_s, drv_c;
  logic [LIMIT_W-1:0]        cmp_c;
  logic                      pin_c;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign measured_speed_o = out_speed_q;
  assign drive_value_o    = out_drive_q;
  assign compare_value_o  = out_cmp_q;
  assign direction_pin_o  = out_pin_q;

  // a zero or negative difference wraps by the full-scale count, one short of 2^CB
  assign cap_diff = {1'b0, cap_q} - {1'b0, last_q};
  assign period_c = (cap_diff[CB] || (cap_diff[CB-1:0] == '0)) ?
                    (cap_diff[CB-1:0] - CB'(1)) : cap_diff[CB-1:0];
  assign rem_sh   = {rem_q, quo_q[SCALE_W-1]};
  assign div_sub  = {1'b0, rem_sh} - {2'b00, period_q};

  assign integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(prev_q);
  assign err_delta = (ERR_W+1)'(err_q) - (ERR_W+1)'(prev_q);

  always_comb begin
    mul_a = MA_W'(gain_p_q);
    mul_b = MB_W'(err_q);
    case (state_q)
      S_MI: begin
        mul_a = MA_W'(gain_i_q);
        mul_b = MB_W'(integ_sum);
      end
      S_MD: begin
        mul_a = MA_W'(gain_d_q);
        mul_b = MB_W'(err_delta);
      end
      default: begin
        mul_a = MA_W'(gain_p_q);
        mul_b = MB_W'(err_q);
      end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign prod_sh = prod_q >>> GAIN_FRAC_BITS;
  assign prod_hi = prod_sh[PROD_W-1:INTEG_W-1];

  always_comb begin
    if ((&prod_hi) || !(|prod_hi)) begin
      integ_sat = prod_sh[INTEG_W-1:0];
    end else if (prod_sh[PROD_W-1]) begin
      integ_sat = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      integ_sat = {1'b0, {(INTEG_W-1){1'b1}}};
    end
  end

  assign lim_pos = ACC_W'({1'b0, limit_q});

  always_comb begin
    per_s = (DRIVE_W+1)'({1'b0, pwm_q});
    drv_s = (DRIVE_W+1)'(drive_q);
    if (drv_s > per_s) begin
      drv_c = per_s;
    end else if (drv_s < -per_s) begin
      drv_c = -per_s;
    end else begin
      drv_c = drv_s;
    end
    if (side_q) begin
      if (!drv_c[DRIVE_W]) begin
        cmp_c = drv_c[LIMIT_W-1:0];
        pin_c = 1'b0;
      end else begin
        cmp_c = LIMIT_W'(per_s + drv_c);
        pin_c = 1'b1;
      end
    end else begin
      if (!drv_c[DRIVE_W]) begin
        cmp_c = LIMIT_W'(per_s - drv_c);
        pin_c = 1'b1;
      end else begin
        cmp_c = LIMIT_W'(-drv_c);
        pin_c = 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = (command_i == CMD_TICK) ? S_ERR : S_CAP;
        end
      end
      S_CAP:   state_d = (period_c == '0) ? S_SIGN : S_DIV;
      S_DIV:   state_d = (cnt_q == CNT_W'(1)) ? S_SIGN : S_DIV;
      S_SIGN:  state_d = S_MAP;
      S_ERR:   state_d = S_MP;
      S_MP:    state_d = S_MI;
      S_MI:    state_d = S_MD;
      S_MD:    state_d = S_SUM;
      S_SUM:   state_d = S_CLAMP;
      S_CLAMP: state_d = S_MAP;
      S_MAP:   state_d = out_free ? S_IDLE : S_MAP;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_RST;
      gain_p_q <= GAIN_P_RST;
      gain_i_q <= GAIN_I_RST;
      gain_d_q <= GAIN_D_RST;
      limit_q  <= LIMIT_RST;
      pwm_q    <= PWM_RST;
      side_q   <= SIDE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SPEED_SCALE: scale_q  <= cfg_data_i[SCALE_W-1:0];
        REG_GAIN_P:      gain_p_q <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:      gain_i_q <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:      gain_d_q <= cfg_data_i[GAIN_W-1:0];
        REG_OUT_LIMIT:   limit_q  <= cfg_data_i[LIMIT_W-1:0];
        REG_PWM_PERIOD:  pwm_q    <= cfg_data_i[LIMIT_W-1:0];
        REG_WHEEL_SIDE:  side_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q    <= command_i;
      cap_q    <= capture_value_i;
      level_q  <= direction_level_i;
      target_q <= target_speed_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CAP: begin
        period_q <= period_c;
        rem_q    <= '0;
        quo_q    <= (period_c == '0) ? {SCALE_W{1'b1}} : scale_q;
        cnt_q    <= CNT_W'(SCALE_W);
      end
      S_DIV: begin
        if (!div_sub[CB+1]) begin
          rem_q <= div_sub[CB-1:0];
        end else begin
          rem_q <= rem_sh[CB-1:0];
        end
        quo_q <= {quo_q[SCALE_W-2:0], !div_sub[CB+1]};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      S_ERR: err_q <= ERR_W'(target_q) - ERR_W'(speed_q);
      S_MP: prod_q <= prod_d;
      S_MI: begin
        prod_q <= prod_d;
        acc_q  <= ACC_W'(prod_sh);
      end
      S_MD: begin
        prod_q <= prod_d;
        acc_q  <= acc_q + ACC_W'(integ_sat);
      end
      S_SUM: acc_q <= acc_q + ACC_W'(prod_sh);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      speed_q <= '0;
      integ_q <= '0;
      prev_q  <= '0;
      drive_q <= '0;
    end else begin
      case (state_q)
        S_CAP: last_q <= cap_q;
        S_SIGN: begin
          if (level_q == side_q) begin
            speed_q <= SPEED_W'({1'b0, quo_q});
          end else begin
            speed_q <= -SPEED_W'({1'b0, quo_q});
          end
        end
        S_MD:  integ_q <= integ_sat;
        S_SUM: prev_q <= err_q;
        S_CLAMP: begin
          if (acc_q > lim_pos) begin
            drive_q <= DRIVE_W'(lim_pos);
          end else if (acc_q < -lim_pos) begin
            drive_q <= DRIVE_W'(-lim_pos);
          end else begin
            drive_q <= DRIVE_W'(acc_q);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_MAP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MAP && out_free) begin
      out_speed_q <= speed_q;
      out_drive_q <= drive_q;
      out_cmp_q   <= cmp_c;
      out_pin_q   <= pin_c;
    end
  end

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q != '0)
    else $error("divider step with exhausted count");

  a_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == S_CAP) == ($past(command_i) == CMD_CAPTURE))
    else $error("request dispatched to wrong path");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAP && out_free |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded on free output");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_MAP))
    else $error("result raised outside map step");

  a_busy_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |=> !$past(cmd_q))
    else $error("tick request entered divider");

endmodule

`default_nettype wire
